/* rtl/jtl_pkg.sv */
// Shared types, constants and helper functions for the JSON token lexer.
// Used by jtl_front, jtl_queue, jtl_back and json_token_lexer_core.
package jtl_pkg;

  localparam int PositionBits = 32;
  localparam int QueueDepth   = 4;
  localparam int QueueAw      = $clog2(QueueDepth);
  localparam int MaxResults   = 3;

  typedef enum logic [2:0] {
    ModeIdle,
    ModeNumber,
    ModeString,
    ModeWord,
    ModeHalt
  } mode_e;

  typedef enum logic [1:0] {
    KindText,
    KindToken,
    KindError
  } kind_e;

  typedef enum logic [3:0] {
    TokInt,
    TokFloat,
    TokString,
    TokTrue,
    TokFalse,
    TokNull,
    TokLbrace,
    TokRbrace,
    TokLbrack,
    TokRbrack,
    TokColon,
    TokComma,
    TokEnd
  } tok_e;

  typedef enum logic [1:0] {
    ErrNumber,
    ErrLineInString,
    ErrIdent,
    ErrIllegalChar
  } err_e;

  localparam logic [7:0] CharMinus  = 8'h2D;
  localparam logic [7:0] CharDot    = 8'h2E;
  localparam logic [7:0] CharQuote  = 8'h22;
  localparam logic [7:0] CharLf     = 8'h0A;
  localparam logic [7:0] CharCr     = 8'h0D;
  localparam logic [7:0] CharTab    = 8'h09;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;
  localparam logic [7:0] CharLowA   = 8'h61;
  localparam logic [7:0] CharLowZ   = 8'h7A;
  localparam logic [7:0] CharLowT   = 8'h74;
  localparam logic [7:0] CharLowF   = 8'h66;
  localparam logic [7:0] CharLowN   = 8'h6E;
  localparam logic [7:0] CharLbrace = 8'h7B;
  localparam logic [7:0] CharRbrace = 8'h7D;
  localparam logic [7:0] CharLbrack = 8'h5B;
  localparam logic [7:0] CharRbrack = 8'h5D;
  localparam logic [7:0] CharColon  = 8'h3A;
  localparam logic [7:0] CharComma  = 8'h2C;

  // keyword spellings: true, false, null
  localparam logic [2:0][4:0][7:0] KwText = '{
    '{8'h00, 8'h6C, 8'h6C, 8'h75, 8'h6E},
    '{8'h65, 8'h73, 8'h6C, 8'h61, 8'h66},
    '{8'h00, 8'h65, 8'h75, 8'h72, 8'h74}
  };
  localparam logic [2:0][2:0] KwLen  = '{3'd4, 3'd5, 3'd4};
  localparam tok_e            KwType [3] = '{TokTrue, TokFalse, TokNull};

  typedef struct packed {
    kind_e       kind;
    tok_e        ttype;
    logic [7:0]  text;
    err_e        code;
    logic [31:0] pos;
  } res_t;

  typedef struct packed {
    logic [1:0]      count;
    res_t [2:0]      res;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic res_t mk_res(kind_e kind, tok_e ttype, logic [7:0] text, err_e code,
                                  logic [31:0] pos);
    res_t r;
    r.kind  = kind;
    r.ttype = ttype;
    r.text  = text;
    r.code  = code;
    r.pos   = pos;
    return r;
  endfunction

  function automatic bundle_t push_res(bundle_t b, res_t r);
    bundle_t o;
    o = b;
    if (b.count != 2'd3) begin
      o.res[b.count] = r;
      o.count        = 2'(b.count + 2'd1);
    end
    return o;
  endfunction

  function automatic logic [7:0] kw_char(logic [1:0] k, logic [2:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    if (idx < 3'd5) begin
      ch = KwText[k][idx];
    end
    return ch;
  endfunction

  // returns {candidates, length}
  function automatic logic [5:0] word_take(logic [2:0] cand, logic [2:0] len, logic [7:0] ch);
    logic [2:0] nc;
    logic [2:0] nl;
    nc = cand;
    for (int k = 0; k < 3; k++) begin
      if (!(len < KwLen[k] && kw_char(2'(k), len) == ch)) begin
        nc[k] = 1'b0;
      end
    end
    nl = (len != 3'd7) ? 3'(len + 3'd1) : len;
    return {nc, nl};
  endfunction

  // returns {found, token type}
  function automatic logic [4:0] word_match(logic [2:0] cand, logic [2:0] len);
    logic       found;
    tok_e       t;
    found = 1'b0;
    t     = TokTrue;
    for (int k = 0; k < 3; k++) begin
      if (!found && cand[k] && len == KwLen[k]) begin
        found = 1'b1;
        t     = KwType[k];
      end
    end
    return {found, t};
  endfunction

endpackage

/* rtl/jtl_front.sv */
// Front end: takes one character item per cycle while the queue is not full, runs the lexer
// state and bundles the up to three results into one queue entry. Depends on jtl_pkg.
module jtl_front #(
  parameter int POSITION_BITS = jtl_pkg::PositionBits
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       char_byte_i,
  input  logic             has_char_i,
  input  logic             doc_start_i,
  input  logic             doc_end_i,
  input  logic             q_full_i,
  output logic             push_o,
  output jtl_pkg::bundle_t push_data_o
);

  localparam int ExtBits = (POSITION_BITS > 33) ? POSITION_BITS : 33;

  jtl_pkg::mode_e           mode_q, mode_d;
  logic                     sfd_q, sfd_d;
  logic                     pwd_q, pwd_d;
  logic [2:0]               wlen_q, wlen_d;
  logic [2:0]               wcand_q, wcand_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;

  logic [POSITION_BITS-1:0] pos_base, pos_next, pos_end;
  logic [31:0]              cur32, end32;
  logic                     halted, accept;
  jtl_pkg::bundle_t         b;

  function automatic logic [31:0] sat32(logic [POSITION_BITS-1:0] v);
    logic [ExtBits-1:0] e;
    e = ExtBits'(v);
    return (|e[ExtBits-1:32]) ? 32'hFFFF_FFFF : e[31:0];
  endfunction

  assign accept    = in_valid_i && in_ready_o;
  assign in_ready_o = !q_full_i;
  assign pos_base  = doc_start_i ? '0 : pos_q;
  assign pos_next  = (pos_base != '1) ? POSITION_BITS'(pos_base + 1'b1) : pos_base;
  assign pos_end   = has_char_i ? pos_next : pos_base;
  assign cur32     = sat32(pos_base);
  assign end32     = sat32(pos_end);
  assign halted    = !doc_start_i && (mode_q == jtl_pkg::ModeHalt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= jtl_pkg::ModeIdle;
      sfd_q   <= 1'b0;
      pwd_q   <= 1'b0;
      wlen_q  <= 3'd0;
      wcand_q <= 3'b111;
      pos_q   <= '0;
    end else if (accept) begin
      mode_q  <= mode_d;
      sfd_q   <= sfd_d;
      pwd_q   <= pwd_d;
      wlen_q  <= wlen_d;
      wcand_q <= wcand_d;
      pos_q   <= pos_d;
    end
  end

  always_comb begin
    logic [7:0] c;
    logic       cont;
    logic       is_dig;
    logic       crowd;
    logic [5:0] wt;
    logic [4:0] wm;

    c       = char_byte_i;
    is_dig  = (c >= jtl_pkg::CharZero) && (c <= jtl_pkg::CharNine);
    cont    = 1'b0;
    crowd   = 1'b0;
    wt      = '0;
    wm      = '0;
    b       = '0;
    mode_d  = mode_q;
    sfd_d   = sfd_q;
    pwd_d   = pwd_q;
    wlen_d  = wlen_q;
    wcand_d = wcand_q;
    pos_d   = halted ? pos_q : pos_end;

    if (doc_start_i) begin
      mode_d  = jtl_pkg::ModeIdle;
      sfd_d   = 1'b0;
      pwd_d   = 1'b0;
      wlen_d  = 3'd0;
      wcand_d = 3'b111;
    end

    if (mode_d != jtl_pkg::ModeHalt) begin
      if (has_char_i) begin
        cont = 1'b1;
        case (mode_d)
          jtl_pkg::ModeNumber: begin
            if (is_dig) begin
              b     = jtl_pkg::push_res(b, jtl_pkg::mk_res(jtl_pkg::KindText, jtl_pkg::TokInt,
                                        c, jtl_pkg::ErrNumber, cur32));
              pwd_d = 1'b1;
              cont  = 1'b0;
            end else if (c == jtl_pkg::CharDot) begin
              cont = 1'b0;
              if (sfd_d || !pwd_d) begin
                b      = jtl_pkg::push_res(b, jtl_pkg::mk_res(jtl_pkg::KindError,
                                           jtl_pkg::TokInt, 8'h00, jtl_pkg::ErrNumber, cur32));
                mode_d = jtl_pkg::ModeHalt;
              end else begin
                sfd_d = 1'b1;
                pwd_d = 1'b0;
                b     = jtl_pkg::push_res(b, jtl_pkg::mk_res(jtl_pkg::KindText,
                                          jtl_pkg::TokInt, c, jtl_pkg::ErrNumber, cur32));
              end
            end else begin
              b      = jtl_pkg::push_res(b, jtl_pkg::mk_res(jtl_pkg::KindToken,
                                         sfd_d ? jtl_pkg::TokFloat : jtl_pkg::TokInt,
                                         8'h00, jtl_pkg::ErrNumber, cur32));
              mode_d = jtl_pkg::ModeIdle;
            end
          end
          jtl_pkg::ModeString: begin
            cont = 1'b0;
            if (c == jtl_pkg::CharQuote) begin
              b      = jtl_pkg::push_res(b, jtl_pkg::mk_res(jtl_pkg::KindToken,
                                         jtl_pkg::TokString, 8'h00, jtl_pkg::ErrNumber, cur32));
              mode_d = jtl_pkg::ModeIdle;
            end else if (c == jtl_pkg::CharLf || c == jtl_pkg::CharCr) begin
              b      = jtl_pkg::push_res(b, jtl_pkg::mk_res(jtl_pkg::KindError,
                                         jtl_pkg::TokInt, 8'h00, jtl_pkg::ErrLineInString,
                                         cur32));
              mode_d = jtl_pkg::ModeHalt;
            end else begin
              b = jtl_pkg::push_res(b, jtl_pkg::mk_res(jtl_pkg::KindText, jtl_pkg::TokString,
                                    c, jtl_pkg::ErrNumber, cur32));
            end
          end
          jtl_pkg::ModeWord: begin
            if (c >= jtl_pkg::CharLowA && c <= jtl_pkg::CharLowZ) begin
              wt      = jtl_pkg::word_take(wcand_d, wlen_d, c);
              wcand_d = wt[5:3];
              wlen_d  = wt[2:0];
              cont    = 1'b0;
            end else begin
              wm = jtl_pkg::word_match(wcand_d, wlen_d);
              if (wm[4]) begin
                b      = jtl_pkg::push_res(b, jtl_pkg::mk_res(jtl_pkg::KindToken,
                                           jtl_pkg::tok_e'(wm[3:0]), 8'h00,
                                           jtl_pkg::ErrNumber, cur32));
                mode_d = jtl_pkg::ModeIdle;
              end else begin
                b      = jtl_pkg::push_res(b, jtl_pkg::mk_res(jtl_pkg::KindError,
                                           jtl_pkg::TokInt, 8'h00, jtl_pkg::ErrIdent, cur32));
                mode_d = jtl_pkg::ModeHalt;
                cont   = 1'b0;
              end
            end
          end
          default: ;
        endcase

        if (cont) begin
          if (c == jtl_pkg::CharSpace || (c >= jtl_pkg::CharTab && c <= jtl_pkg::CharCr)) begin
            cont = 1'b0;
          end else if (is_dig || c == jtl_pkg::CharMinus) begin
            crowd  = doc_end_i && (b.count != 2'd0);
            mode_d = jtl_pkg::ModeNumber;
            sfd_d  = 1'b0;
            pwd_d  = is_dig;
            if (!crowd) begin
              b = jtl_pkg::push_res(b, jtl_pkg::mk_res(jtl_pkg::KindText, jtl_pkg::TokInt,
                                    c, jtl_pkg::ErrNumber, cur32));
            end
          end else begin
            case (c)
              jtl_pkg::CharQuote: mode_d = jtl_pkg::ModeString;
              jtl_pkg::CharLowT, jtl_pkg::CharLowF, jtl_pkg::CharLowN: begin
                mode_d  = jtl_pkg::ModeWord;
                wt      = jtl_pkg::word_take(3'b111, 3'd0, c);
                wcand_d = wt[5:3];
                wlen_d  = wt[2:0];
              end
              jtl_pkg::CharLbrace: b = jtl_pkg::push_res(b, jtl_pkg::mk_res(jtl_pkg::KindToken,
                                       jtl_pkg::TokLbrace, 8'h00, jtl_pkg::ErrNumber, cur32));
              jtl_pkg::CharRbrace: b = jtl_pkg::push_res(b, jtl_pkg::mk_res(jtl_pkg::KindToken,
                                       jtl_pkg::TokRbrace, 8'h00, jtl_pkg::ErrNumber, cur32));
              jtl_pkg::CharLbrack: b = jtl_pkg::push_res(b, jtl_pkg::mk_res(jtl_pkg::KindToken,
                                       jtl_pkg::TokLbrack, 8'h00, jtl_pkg::ErrNumber, cur32));
              jtl_pkg::CharRbrack: b = jtl_pkg::push_res(b, jtl_pkg::mk_res(jtl_pkg::KindToken,
                                       jtl_pkg::TokRbrack, 8'h00, jtl_pkg::ErrNumber, cur32));
              jtl_pkg::CharColon:  b = jtl_pkg::push_res(b, jtl_pkg::mk_res(jtl_pkg::KindToken,
                                       jtl_pkg::TokColon, 8'h00, jtl_pkg::ErrNumber, cur32));
              jtl_pkg::CharComma:  b = jtl_pkg::push_res(b, jtl_pkg::mk_res(jtl_pkg::KindToken,
                                       jtl_pkg::TokComma, 8'h00, jtl_pkg::ErrNumber, cur32));
              default: begin
                b      = jtl_pkg::push_res(b, jtl_pkg::mk_res(jtl_pkg::KindError,
                                           jtl_pkg::TokInt, 8'h00, jtl_pkg::ErrIllegalChar,
                                           cur32));
                mode_d = jtl_pkg::ModeHalt;
              end
            endcase
          end
        end
      end

      if (doc_end_i && mode_d != jtl_pkg::ModeHalt) begin
        case (mode_d)
          jtl_pkg::ModeNumber: begin
            b      = jtl_pkg::push_res(b, jtl_pkg::mk_res(jtl_pkg::KindToken,
                                       sfd_d ? jtl_pkg::TokFloat : jtl_pkg::TokInt,
                                       8'h00, jtl_pkg::ErrNumber, end32));
            mode_d = jtl_pkg::ModeIdle;
          end
          jtl_pkg::ModeString: begin
            b      = jtl_pkg::push_res(b, jtl_pkg::mk_res(jtl_pkg::KindError, jtl_pkg::TokInt,
                                       8'h00, jtl_pkg::ErrLineInString, end32));
            mode_d = jtl_pkg::ModeHalt;
          end
          jtl_pkg::ModeWord: begin
            wm = jtl_pkg::word_match(wcand_d, wlen_d);
            if (wm[4]) begin
              b      = jtl_pkg::push_res(b, jtl_pkg::mk_res(jtl_pkg::KindToken,
                                         jtl_pkg::tok_e'(wm[3:0]), 8'h00,
                                         jtl_pkg::ErrNumber, end32));
              mode_d = jtl_pkg::ModeIdle;
            end else begin
              b      = jtl_pkg::push_res(b, jtl_pkg::mk_res(jtl_pkg::KindError,
                                         jtl_pkg::TokInt, 8'h00, jtl_pkg::ErrIdent, end32));
              mode_d = jtl_pkg::ModeHalt;
            end
          end
          default: ;
        endcase
        if (mode_d != jtl_pkg::ModeHalt) begin
          b      = jtl_pkg::push_res(b, jtl_pkg::mk_res(jtl_pkg::KindToken, jtl_pkg::TokEnd,
                                     8'h00, jtl_pkg::ErrNumber, end32));
          mode_d = jtl_pkg::ModeIdle;
        end
      end
    end
  end

  assign push_o      = accept && (b.count != 2'd0);
  assign push_data_o = b;

endmodule

/* rtl/jtl_queue.sv */
// Short bundle queue between the front end and the back end.
// Depends on jtl_pkg for the bundle type and depth.
module jtl_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  jtl_pkg::bundle_t    push_data_i,
  input  logic                pop_i,
  output jtl_pkg::bundle_t    head_o,
  output jtl_pkg::q_status_t  status_o
);

  jtl_pkg::bundle_t               mem_q [jtl_pkg::QueueDepth];
  logic [jtl_pkg::QueueAw-1:0]    wptr_q, rptr_q;
  logic [jtl_pkg::QueueAw:0]      cnt_q, cnt_d;
  logic                           do_push, do_pop;

  assign status_o.full  = (cnt_q == (jtl_pkg::QueueAw + 1)'(jtl_pkg::QueueDepth));
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = mem_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = (jtl_pkg::QueueAw + 1)'(cnt_q + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_d = (jtl_pkg::QueueAw + 1)'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wptr_q <= jtl_pkg::QueueAw'(wptr_q + 1'b1);
      end
      if (do_pop) begin
        rptr_q <= jtl_pkg::QueueAw'(rptr_q + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/jtl_back.sv */
// Back end: walks the results of the head bundle one per transfer and
// marks the last one of each item. Depends on jtl_pkg.
module jtl_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  jtl_pkg::bundle_t head_i,
  input  logic             empty_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output jtl_pkg::res_t    out_res_o,
  output logic             out_last_o
);

  logic [1:0] idx_q, idx_d;
  logic       xfer;

  assign out_valid_o = !empty_i;
  assign out_res_o   = head_i.res[idx_q];
  assign out_last_o  = (idx_q == 2'(head_i.count - 2'd1));
  assign xfer        = out_valid_o && out_ready_i;
  assign pop_o       = xfer && out_last_o;

  always_comb begin
    idx_d = idx_q;
    if (xfer) begin
      idx_d = out_last_o ? 2'd0 : 2'(idx_q + 2'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

/* rtl/json_token_lexer_core.sv */
// JSON token lexer top level: front end, bundle queue, back end.
// The results of an accepted character are registered in the bundle queue before they reach the output.
// Throughput: one character per cycle while the queue is not full; results leave at one
// per cycle while the output is ready, through the single result port.
// Reset (rst_ni low, asynchronous): lexer idle, position zero, queue empty.
// Depends on jtl_pkg, jtl_front, jtl_queue, jtl_back.
module json_token_lexer_core #(
  parameter int POSITION_BITS = jtl_pkg::PositionBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_byte
  input  logic [1:0]  s_axis_tuser_i,   // [0] has_char, [1] doc_start
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // [3:0] token_type, [11:4] text_byte,
                                        // [13:12] error_code, [45:14] token_position
  output logic [1:0]  m_axis_tuser_o,   // [1:0] item_kind
  output logic        m_axis_tlast_o
);

  logic               push, pop;
  jtl_pkg::bundle_t   push_data, head;
  jtl_pkg::q_status_t q_stat;
  jtl_pkg::res_t      res;

  jtl_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .char_byte_i (s_axis_tdata_i),
    .has_char_i  (s_axis_tuser_i[0]),
    .doc_start_i (s_axis_tuser_i[1]),
    .doc_end_i   (s_axis_tlast_i),
    .q_full_i    (q_stat.full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  jtl_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_stat)
  );

  jtl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (q_stat.empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_res_o   (res),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {2'b00, res.pos, res.code, res.text, res.ttype};
  assign m_axis_tuser_o = res.kind;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && q_stat.full))
    else $error("bundle pushed into a full queue");

  a_push_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (push_data.count != 2'd0))
    else $error("empty bundle pushed");

  a_valid_tracks_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o == !q_stat.empty)
    else $error("output valid out of step with queue");

  a_pop_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (m_axis_tlast_o && m_axis_tvalid_o && m_axis_tready_i))
    else $error("queue popped before last result");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for json_token_lexer_core: directed JSON snippets, then random
// documents, with a built-in lexer predictor and random idling on both stream sides.
// Depends on jtl_pkg and the json_token_lexer_core RTL.
module tb_top;

  localparam int LimitCycles = 200000;
  localparam int DrainCycles = 20;
  localparam int RandomItems = 100;
  localparam int MaxReports  = 10;

  typedef struct packed {
    jtl_pkg::kind_e kind;
    jtl_pkg::tok_e  ttype;
    logic [7:0]     text;
    jtl_pkg::err_e  code;
    logic [31:0]    pos;
    logic           last;
  } lex_event_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic [1:0]  s_axis_tuser = 2'b00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  jtl_pkg::mode_e lx_mode;
  logic           frac_seen;
  logic           digit_before;
  logic [2:0]     word_len;
  logic [2:0]     word_cand;
  logic [31:0]    char_pos;
  lex_event_t     item_events[$];
  lex_event_t     pending_events[$];
  string          kw_spell [3] = '{"true", "false", "null"};
  jtl_pkg::tok_e  kw_tok [3] = '{jtl_pkg::TokTrue, jtl_pkg::TokFalse, jtl_pkg::TokNull};

  int          errors = 0;
  int          cycles = 0;
  int          items_sent = 0;
  int          burst_left = 0;
  int          gap_max = 4;
  bit          stall_on = 1'b1;
  logic [15:0] ready_pat = 16'hFFFF;
  logic [3:0]  ready_age = 4'd0;
  logic [7:0]  doc_bytes[$];

  always #4 clk_i = ~clk_i;

  json_token_lexer_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  function automatic void reset_lexer();
    lx_mode      = jtl_pkg::ModeIdle;
    frac_seen    = 1'b0;
    digit_before = 1'b0;
    word_len     = 3'd0;
    word_cand    = 3'b111;
    char_pos     = 32'd0;
  endfunction

  function automatic void emit(jtl_pkg::kind_e k, jtl_pkg::tok_e t, logic [7:0] b,
                               jtl_pkg::err_e c, logic [31:0] p);
    lex_event_t ev;
    ev.kind  = k;
    ev.ttype = t;
    ev.text  = b;
    ev.code  = c;
    ev.pos   = p;
    ev.last  = 1'b0;
    if (item_events.size() < jtl_pkg::MaxResults) item_events = {item_events, ev};
  endfunction

  function automatic void halt_on(jtl_pkg::err_e c, logic [31:0] p);
    emit(jtl_pkg::KindError, jtl_pkg::TokInt, 8'h00, c, p);
    lx_mode = jtl_pkg::ModeHalt;
  endfunction

  function automatic bit is_num_digit(logic [7:0] c);
    return c >= jtl_pkg::CharZero && c <= jtl_pkg::CharNine;
  endfunction

  function automatic void absorb_letter(logic [7:0] c);
    for (int i = 0; i < 3; i++) begin
      if (!(word_len < kw_spell[i].len() && 8'(kw_spell[i][word_len]) == c)) begin
        word_cand[i] = 1'b0;
      end
    end
    if (word_len != 3'd7) word_len = word_len + 3'd1;
  endfunction

  function automatic bit close_word(logic [31:0] p);
    for (int i = 0; i < 3; i++) begin
      if (word_cand[i] && word_len == kw_spell[i].len()) begin
        emit(jtl_pkg::KindToken, kw_tok[i], 8'h00, jtl_pkg::ErrNumber, p);
        lx_mode = jtl_pkg::ModeIdle;
        return 1'b1;
      end
    end
    halt_on(jtl_pkg::ErrIdent, p);
    return 1'b0;
  endfunction

  function automatic void lex_char(logic [7:0] c, logic [31:0] p, bit ending);
    bit crowded;
    case (lx_mode)
      jtl_pkg::ModeNumber: begin
        if (is_num_digit(c)) begin
          emit(jtl_pkg::KindText, jtl_pkg::TokInt, c, jtl_pkg::ErrNumber, p);
          digit_before = 1'b1;
          return;
        end
        if (c == jtl_pkg::CharDot) begin
          if (frac_seen || !digit_before) begin
            halt_on(jtl_pkg::ErrNumber, p);
            return;
          end
          frac_seen    = 1'b1;
          digit_before = 1'b0;
          emit(jtl_pkg::KindText, jtl_pkg::TokInt, c, jtl_pkg::ErrNumber, p);
          return;
        end
        emit(jtl_pkg::KindToken, frac_seen ? jtl_pkg::TokFloat : jtl_pkg::TokInt, 8'h00,
             jtl_pkg::ErrNumber, p);
        lx_mode = jtl_pkg::ModeIdle;
      end
      jtl_pkg::ModeString: begin
        if (c == jtl_pkg::CharQuote) begin
          emit(jtl_pkg::KindToken, jtl_pkg::TokString, 8'h00, jtl_pkg::ErrNumber, p);
          lx_mode = jtl_pkg::ModeIdle;
        end else if (c == jtl_pkg::CharLf || c == jtl_pkg::CharCr) begin
          halt_on(jtl_pkg::ErrLineInString, p);
        end else begin
          emit(jtl_pkg::KindText, jtl_pkg::TokString, c, jtl_pkg::ErrNumber, p);
        end
        return;
      end
      jtl_pkg::ModeWord: begin
        if (c >= jtl_pkg::CharLowA && c <= jtl_pkg::CharLowZ) begin
          absorb_letter(c);
          return;
        end
        if (!close_word(p)) return;
      end
      default: ;
    endcase
    if (c == jtl_pkg::CharSpace || (c >= jtl_pkg::CharTab && c <= jtl_pkg::CharCr)) return;
    if (is_num_digit(c) || c == jtl_pkg::CharMinus) begin
      crowded      = ending && item_events.size() >= 1;
      lx_mode      = jtl_pkg::ModeNumber;
      frac_seen    = 1'b0;
      digit_before = is_num_digit(c);
      if (!crowded) emit(jtl_pkg::KindText, jtl_pkg::TokInt, c, jtl_pkg::ErrNumber, p);
      return;
    end
    case (c)
      jtl_pkg::CharQuote: lx_mode = jtl_pkg::ModeString;
      jtl_pkg::CharLowT, jtl_pkg::CharLowF, jtl_pkg::CharLowN: begin
        lx_mode   = jtl_pkg::ModeWord;
        word_len  = 3'd0;
        word_cand = 3'b111;
        absorb_letter(c);
      end
      jtl_pkg::CharLbrace:
        emit(jtl_pkg::KindToken, jtl_pkg::TokLbrace, 8'h00, jtl_pkg::ErrNumber, p);
      jtl_pkg::CharRbrace:
        emit(jtl_pkg::KindToken, jtl_pkg::TokRbrace, 8'h00, jtl_pkg::ErrNumber, p);
      jtl_pkg::CharLbrack:
        emit(jtl_pkg::KindToken, jtl_pkg::TokLbrack, 8'h00, jtl_pkg::ErrNumber, p);
      jtl_pkg::CharRbrack:
        emit(jtl_pkg::KindToken, jtl_pkg::TokRbrack, 8'h00, jtl_pkg::ErrNumber, p);
      jtl_pkg::CharColon:
        emit(jtl_pkg::KindToken, jtl_pkg::TokColon, 8'h00, jtl_pkg::ErrNumber, p);
      jtl_pkg::CharComma:
        emit(jtl_pkg::KindToken, jtl_pkg::TokComma, 8'h00, jtl_pkg::ErrNumber, p);
      default: halt_on(jtl_pkg::ErrIllegalChar, p);
    endcase
  endfunction

  // returns 0 when the lexer ignores the transfer
  function automatic bit lex_step(logic [7:0] c, bit has, bit start, bit ending);
    logic [31:0] p;
    item_events.delete();
    if (start) reset_lexer();
    if (lx_mode == jtl_pkg::ModeHalt) return 1'b0;
    if (has) begin
      lex_char(c, char_pos, ending);
      if (char_pos != 32'hFFFF_FFFF) char_pos = char_pos + 32'd1;
    end
    if (ending && lx_mode != jtl_pkg::ModeHalt) begin
      p = char_pos;
      if (lx_mode == jtl_pkg::ModeNumber) begin
        emit(jtl_pkg::KindToken, frac_seen ? jtl_pkg::TokFloat : jtl_pkg::TokInt, 8'h00,
             jtl_pkg::ErrNumber, p);
        lx_mode = jtl_pkg::ModeIdle;
      end else if (lx_mode == jtl_pkg::ModeString) begin
        halt_on(jtl_pkg::ErrLineInString, p);
      end else if (lx_mode == jtl_pkg::ModeWord) begin
        void'(close_word(p));
      end
      if (lx_mode != jtl_pkg::ModeHalt) begin
        emit(jtl_pkg::KindToken, jtl_pkg::TokEnd, 8'h00, jtl_pkg::ErrNumber, p);
        lx_mode = jtl_pkg::ModeIdle;
      end
    end
    if (item_events.size() > 0) item_events[item_events.size() - 1].last = 1'b1;
    pending_events = {pending_events, item_events};
    return 1'b1;
  endfunction

  task automatic send_item(logic [7:0] c, bit has, bit start, bit ending);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left    = burst_left - 1;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tuser  <= {start, has};
    s_axis_tlast  <= ending;
    do @(negedge clk_i); while (!s_axis_tready_o);
    void'(lex_step(c, has, start, ending));
    items_sent++;
    @(posedge clk_i);
  endtask

  task automatic send_text(string s, bit start, bit ending);
    for (int i = 0; i < s.len(); i++) begin
      send_item(8'(s[i]), 1'b1, start && i == 0, ending && i == s.len() - 1);
    end
  endtask

  task automatic test_punctuation();
    send_text("{\t[ ]\n:,\015}\v\f", 1'b1, 1'b1);
  endtask

  task automatic test_numbers();
    send_text("[-1.5,9", 1'b1, 1'b1);
    send_text("true-", 1'b1, 1'b1);
    send_text("1..", 1'b1, 1'b0);
    send_text("-.", 1'b1, 1'b0);
  endtask

  task automatic test_strings();
    send_text("\"a\377 \"", 1'b1, 1'b0);
    send_text("\"x\nq", 1'b1, 1'b0);
    send_text("\"z", 1'b1, 1'b1);
  endtask

  task automatic test_words();
    send_text("null,false", 1'b1, 1'b1);
    send_text("nul", 1'b1, 1'b1);
    send_text("nullnulls ", 1'b1, 1'b0);
    send_text("t@", 1'b1, 1'b0);
  endtask

  task automatic test_halt_and_markers();
    send_text("@x", 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1, 1'b0);
    send_item(jtl_pkg::CharNine, 1'b1, 1'b1, 1'b0);
    send_item(jtl_pkg::CharQuote, 1'b1, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0, 1'b1);
    send_text("[]", 1'b1, 1'b1);
    send_text("]", 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b0, 1'b1);
  endtask

  function automatic logic [7:0] string_char();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == jtl_pkg::CharQuote || b == jtl_pkg::CharLf || b == jtl_pkg::CharCr);
    return b;
  endfunction

  function automatic void put_byte(logic [7:0] b);
    doc_bytes = {doc_bytes, b};
  endfunction

  function automatic void add_token(bit noisy);
    int   r;
    int   n;
    logic [7:0] punct [6] = '{jtl_pkg::CharLbrace, jtl_pkg::CharRbrace, jtl_pkg::CharLbrack,
                             jtl_pkg::CharRbrack, jtl_pkg::CharColon, jtl_pkg::CharComma};
    logic [7:0] blank [6] = '{jtl_pkg::CharSpace, jtl_pkg::CharTab, jtl_pkg::CharLf, 8'h0B,
                             8'h0C, jtl_pkg::CharCr};
    string      broken [4] = '{"tru", "1.2.", "-.5", "nulll"};
    r = $urandom_range(0, noisy ? 11 : 8);
    case (r)
      0, 1: put_byte(punct[$urandom_range(0, 5)]);
      2: put_byte(blank[$urandom_range(0, 5)]);
      3, 4: begin
        if ($urandom_range(0, 2) == 0) put_byte(jtl_pkg::CharMinus);
        n = $urandom_range(1, 4);
        repeat (n) put_byte(8'(jtl_pkg::CharZero + $urandom_range(0, 9)));
        if ($urandom_range(0, 2) == 0) begin
          put_byte(jtl_pkg::CharDot);
          n = $urandom_range(1, 3);
          repeat (n) put_byte(8'(jtl_pkg::CharZero + $urandom_range(0, 9)));
        end
      end
      5, 6: begin
        put_byte(jtl_pkg::CharQuote);
        n = $urandom_range(0, 5);
        repeat (n) put_byte(string_char());
        put_byte(jtl_pkg::CharQuote);
      end
      7: begin
        n = $urandom_range(0, 2);
        for (int i = 0; i < kw_spell[n].len(); i++) put_byte(8'(kw_spell[n][i]));
      end
      8: put_byte(jtl_pkg::CharSpace);
      9: put_byte(8'($urandom_range(0, 255)));
      10: begin
        n = $urandom_range(0, 3);
        for (int i = 0; i < broken[n].len(); i++) put_byte(8'(broken[n][i]));
      end
      default: begin
        put_byte(jtl_pkg::CharQuote);
        put_byte(string_char());
        put_byte($urandom_range(0, 1) ? jtl_pkg::CharLf : jtl_pkg::CharCr);
      end
    endcase
  endfunction

  task automatic test_random_documents();
    int  first;
    int  n;
    bit  noisy;
    bit  close_doc;
    bit  bare_end;
    first = items_sent;
    while (items_sent - first < RandomItems) begin
      case ($urandom_range(0, 3))
        0: gap_max = 0;
        1: gap_max = 2;
        2: gap_max = 8;
        default: gap_max = 4;
      endcase
      stall_on  = $urandom_range(0, 3) != 0;
      noisy     = $urandom_range(0, 3) == 0;
      close_doc = $urandom_range(0, 7) != 0;
      bare_end  = close_doc && $urandom_range(0, 4) == 0;
      doc_bytes.delete();
      n = $urandom_range(2, 10);
      repeat (n) add_token(noisy);
      foreach (doc_bytes[i]) begin
        if (i != 0 && $urandom_range(0, 19) == 0) begin
          send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
        end
        send_item(doc_bytes[i], 1'b1, i == 0,
                  close_doc && !bare_end && i == doc_bytes.size() - 1);
      end
      if (bare_end) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b1);
    end
  endtask

  always @(posedge clk_i) begin
    if (!stall_on) begin
      m_axis_tready <= 1'b1;
    end else begin
      if (ready_age == 4'd0) ready_pat = 16'($urandom) | 16'h0001;
      m_axis_tready <= ready_pat[ready_age];
      ready_age = ready_age + 4'd1;
    end
  end

  always @(negedge clk_i) begin
    lex_event_t got;
    lex_event_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready) begin
      got.kind  = jtl_pkg::kind_e'(m_axis_tuser_o);
      got.ttype = jtl_pkg::tok_e'(m_axis_tdata_o[3:0]);
      got.text  = m_axis_tdata_o[11:4];
      got.code  = jtl_pkg::err_e'(m_axis_tdata_o[13:12]);
      got.pos   = m_axis_tdata_o[45:14];
      got.last  = m_axis_tlast_o;
      if (pending_events.size() == 0) begin
        errors++;
        if (errors <= MaxReports) begin
          $display("unexpected transfer: kind %0d type %0d byte %02h code %0d pos %0d last %0b",
                   got.kind, got.ttype, got.text, got.code, got.pos, got.last);
        end
      end else begin
        want = pending_events.pop_front();
        if (got.kind !== want.kind || got.ttype !== want.ttype || got.text !== want.text ||
            got.code !== want.code || got.pos !== want.pos || got.last !== want.last) begin
          errors++;
          if (errors <= MaxReports) begin
            $display("mismatch: expected kind %0d type %0d byte %02h code %0d pos %0d last %0b",
                     want.kind, want.ttype, want.text, want.code, want.pos, want.last);
            $display("          got      kind %0d type %0d byte %02h code %0d pos %0d last %0b",
                     got.kind, got.ttype, got.text, got.code, got.pos, got.last);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LimitCycles) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    reset_lexer();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_punctuation();
    test_numbers();
    test_strings();
    gap_max  = 0;
    stall_on = 1'b0;
    test_words();
    gap_max  = 4;
    stall_on = 1'b1;
    test_halt_and_markers();
    test_random_documents();
    s_axis_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0 && pending_events.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
